>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the positional array table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must hold at every clock edge out of reset.
`define AST_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define AST_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_ALWAYS(lbl, expr)
`define AST_IMPLY(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/pat_pkg.sv
// Types, codes and constants of the positional array table.
package pat_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned DEF_CAPACITY   = 16;
    localparam int unsigned DEF_ENTRY_BITS = 64;

    // Largest supported capacity and the compare width that covers it and positions
    localparam int unsigned MAX_CAPACITY = 256;
    localparam int unsigned CMP_W        = $clog2(MAX_CAPACITY + 1) + 1;

    // Request operation codes
    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_POP    = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_CHANGE = 3'd4,
        MODE_GET    = 3'd5,
        MODE_SEARCH = 3'd6
    } t_mode;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Request and result payloads
    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  position;
        logic [63:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] entry_out;
        logic [3:0]  found_index;
        logic [4:0]  fill_count;
    } t_rsp;

    // Update applied to the cell row at commit
    typedef enum logic [1:0] {
        K_NONE   = 2'd0,
        K_WRITE  = 2'd1,
        K_INSERT = 2'd2,
        K_REMOVE = 2'd3
    } t_kind;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             commit;
        t_kind            kind;
        logic             search;
        logic [CMP_W-1:0] tgt;
        logic [CMP_W-1:0] cnt;
        logic [CMP_W-1:0] addr;
    } t_cell_ctl;

    // Lookup token passed from cell to cell
    typedef struct packed {
        logic             found;
        logic [CMP_W-1:0] idx;
    } t_probe;

endpackage

>>> sv/pat_cell.sv
// One table cell: holds one entry, shifts with its neighbors, forwards the lookup token.
module pat_cell import pat_pkg::*; #(
    parameter int unsigned ENTRY_BITS = DEF_ENTRY_BITS,
    parameter int unsigned CELL_IDX   = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [ENTRY_BITS-1:0] i_word,
    input  logic [ENTRY_BITS-1:0] i_left,
    input  logic [ENTRY_BITS-1:0] i_right,
    output logic [ENTRY_BITS-1:0] o_entry,
    input  t_probe                i_probe,
    input  logic [ENTRY_BITS-1:0] i_probe_data,
    output t_probe                o_probe,
    output logic [ENTRY_BITS-1:0] o_probe_data
);

    localparam logic [CMP_W-1:0] MY_IDX  = CMP_W'(CELL_IDX);
    localparam logic [CMP_W-1:0] MY_NEXT = CMP_W'(CELL_IDX + 1);

    logic [ENTRY_BITS-1:0] r_entry;
    logic [ENTRY_BITS-1:0] n_entry;
    t_probe                r_probe;
    t_probe                n_probe;
    logic [ENTRY_BITS-1:0] r_pdata;
    logic [ENTRY_BITS-1:0] n_pdata;
    logic                  w_write;
    logic                  w_take_left;
    logic                  w_take_right;
    logic                  w_hit;

    // Which update applies to this cell
    assign w_write      = ((i_ctl.kind == K_WRITE) || (i_ctl.kind == K_INSERT))
                          && (MY_IDX == i_ctl.tgt);
    assign w_take_left  = (i_ctl.kind == K_INSERT) && (MY_IDX > i_ctl.tgt)
                          && (MY_IDX <= i_ctl.cnt);
    assign w_take_right = (i_ctl.kind == K_REMOVE) && (MY_IDX >= i_ctl.tgt)
                          && (MY_NEXT < i_ctl.cnt);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.commit) begin
            if (w_write) begin
                n_entry = i_word;
            end else if (w_take_left) begin
                n_entry = i_left;
            end else if (w_take_right) begin
                n_entry = i_right;
            end
        end
    end

    // Key match for search, address match for reads
    assign w_hit = i_ctl.search ? ((MY_IDX < i_ctl.cnt) && (r_entry == i_word))
                                : (MY_IDX == i_ctl.addr);

    // First hit along the row claims the token
    always_comb begin
        n_probe = i_probe;
        n_pdata = i_probe_data;
        if (!i_probe.found && w_hit) begin
            n_probe.found = 1'b1;
            n_probe.idx   = MY_IDX;
            n_pdata       = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_probe <= n_probe;
        r_pdata <= n_pdata;
    end

    assign o_entry      = r_entry;
    assign o_probe      = r_probe;
    assign o_probe_data = r_pdata;

endmodule

>>> sv/positional_array_table_top.sv
// Top level of the positional array table: request sequencer and the row of cells.
//
//  channel   direction  handshake                 payload
//  request   in         i_start / o_busy          i_req  (t_req)
//  result    out        o_strobe (one cycle)      o_rsp  (t_rsp)
//
// A request is taken when i_start is high and o_busy is low.
// The lookup token walks the cell row one cell a cycle, so o_busy stays high while
// the whole row is scanned and the result strobes in the cycle after; a new request
// can be taken in that strobe cycle.
// Reset clears the fill count and the sequencer; entries are not cleared.
// The result is shown for one cycle only and cannot be held off.
`include "assert_macros.svh"
module positional_array_table_top import pat_pkg::*; #(
    parameter int unsigned CAPACITY   = DEF_CAPACITY,
    parameter int unsigned ENTRY_BITS = DEF_ENTRY_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_strobe,
    output t_rsp o_rsp
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      r_count;
    logic [ENTRY_BITS-1:0] r_word;
    logic [2:0]            r_status;
    t_kind                 r_kind;
    logic [CMP_W-1:0]      r_tgt;
    logic [CMP_W-1:0]      r_addr;
    logic                  r_search;
    logic                  r_readop;
    logic                  r_inc;
    logic                  r_dec;
    logic                  r_strobe;
    t_rsp                  r_rsp;

    logic [2:0]            n_status;
    t_kind                 n_kind;
    logic [CMP_W-1:0]      n_tgt;
    logic [CMP_W-1:0]      n_addr;
    logic                  n_search;
    logic                  n_readop;
    logic                  n_inc;
    logic                  n_dec;
    logic [CNT_W-1:0]      n_count;
    t_rsp                  n_rsp;

    logic                  w_accept;
    logic                  w_commit;
    logic [CMP_W-1:0]      w_cnt;
    logic [CMP_W-1:0]      w_pos;
    logic [CMP_W-1:0]      w_cap;
    logic [CMP_W-1:0]      w_fill;
    t_cell_ctl             w_ctl;

    logic [ENTRY_BITS-1:0] w_entry [CAPACITY];
    logic [ENTRY_BITS-1:0] w_left  [CAPACITY];
    logic [ENTRY_BITS-1:0] w_right [CAPACITY];
    t_probe                w_probe [CAPACITY+1];
    logic [ENTRY_BITS-1:0] w_pdata [CAPACITY+1];

    assign w_accept = i_start && !o_busy;
    assign w_commit = (r_state == S_SCAN) && (r_cnt == CNT_W'(CAPACITY));
    assign w_cnt    = CMP_W'(r_count);
    assign w_pos    = CMP_W'(i_req.position);
    assign w_cap    = CMP_W'(CAPACITY);

    // Decode the request against the current fill count
    always_comb begin
        n_status = ST_OK;
        n_kind   = K_NONE;
        n_tgt    = '0;
        n_addr   = '0;
        n_search = 1'b0;
        n_readop = 1'b0;
        n_inc    = 1'b0;
        n_dec    = 1'b0;
        case (t_mode'(i_req.mode))
            MODE_APPEND: begin
                if (w_cnt >= w_cap) begin
                    n_status = ST_FULL;
                end else begin
                    n_kind = K_WRITE;
                    n_tgt  = w_cnt;
                    n_inc  = 1'b1;
                end
            end
            MODE_POP: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_addr   = w_cnt - CMP_W'(1);
                    n_readop = 1'b1;
                    n_dec    = 1'b1;
                end
            end
            MODE_INSERT: begin
                if (w_cnt >= w_cap) begin
                    n_status = ST_FULL;
                end else if (w_pos > w_cnt) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_kind = K_INSERT;
                    n_tgt  = w_pos;
                    n_inc  = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_kind   = K_REMOVE;
                    n_tgt    = w_pos;
                    n_addr   = w_pos;
                    n_readop = 1'b1;
                    n_dec    = 1'b1;
                end
            end
            MODE_CHANGE: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_kind = K_WRITE;
                    n_tgt  = w_pos;
                end
            end
            MODE_GET: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_addr   = w_pos;
                    n_readop = 1'b1;
                end
            end
            MODE_SEARCH: begin
                n_search = 1'b1;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Latch the decoded request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word   <= i_req.value[ENTRY_BITS-1:0];
            r_status <= n_status;
            r_kind   <= n_kind;
            r_tgt    <= n_tgt;
            r_addr   <= n_addr;
            r_search <= n_search;
            r_readop <= n_readop;
            r_inc    <= n_inc;
            r_dec    <= n_dec;
        end
    end

    // Sequencer: scan the row, then commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                        r_cnt   <= '0;
                    end
                end
                S_SCAN: begin
                    if (w_commit) begin
                        r_state  <= S_IDLE;
                        r_count  <= n_count;
                        r_strobe <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result assembly at commit
    always_comb begin
        n_count = r_count;
        if (r_inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (r_dec) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_fill = CMP_W'(n_count);

    always_comb begin
        n_rsp             = '0;
        n_rsp.status      = r_status;
        n_rsp.fill_count  = w_fill[4:0];
        if (r_readop) begin
            n_rsp.entry_out = 64'(w_pdata[CAPACITY]);
        end
        if (r_search) begin
            if (w_probe[CAPACITY].found) begin
                n_rsp.status      = ST_OK;
                n_rsp.found_index = w_probe[CAPACITY].idx[3:0];
            end else begin
                n_rsp.status = ST_NOTFOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_rsp <= n_rsp;
        end
    end

    // Broadcast control to the cells
    always_comb begin
        w_ctl        = '0;
        w_ctl.commit = w_commit;
        w_ctl.kind   = r_kind;
        w_ctl.search = r_search;
        w_ctl.tgt    = r_tgt;
        w_ctl.cnt    = w_cnt;
        w_ctl.addr   = r_addr;
    end

    assign w_probe[0] = '0;
    assign w_pdata[0] = '0;

    // Row of cells
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign w_left[gi] = '0;
        end else begin : g_mid
            assign w_left[gi] = w_entry[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign w_right[gi] = '0;
        end else begin : g_inner
            assign w_right[gi] = w_entry[gi+1];
        end

        pat_cell #(
            .ENTRY_BITS (ENTRY_BITS),
            .CELL_IDX   (gi)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_word       (r_word),
            .i_left       (w_left[gi]),
            .i_right      (w_right[gi]),
            .o_entry      (w_entry[gi]),
            .i_probe      (w_probe[gi]),
            .i_probe_data (w_pdata[gi]),
            .o_probe      (w_probe[gi+1]),
            .o_probe_data (w_pdata[gi+1])
        );
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // Checks
    `AST_ALWAYS(a_count_bound, r_count <= CNT_W'(CAPACITY))
    `AST_ALWAYS(a_scan_bound, r_cnt <= CNT_W'(CAPACITY))
    `AST_NEXT(a_accept_busy, w_accept, o_busy)
    `AST_NEXT(a_commit_strobe, w_commit, o_strobe && !o_busy)
    `AST_IMPLY(a_strobe_after_scan, o_strobe, $past(w_commit))

endmodule

>>> tb/sv/pat_table_checker.sv
// Result checker for the positional array table: tracks the table and compares every result.
module pat_table_checker import pat_pkg::*; #(
    parameter int unsigned CAPACITY   = DEF_CAPACITY,
    parameter int unsigned ENTRY_BITS = DEF_ENTRY_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_req     i_req,
    input  logic     i_strobe,
    input  t_rsp     i_rsp,
    output int       o_fail_count,
    output int       o_outstanding,
    output int       o_checked,
    output bit [4:0] o_status_seen,
    output int       o_fill_peak
);

    localparam int          MAX_REPORTS = 10;
    localparam logic [63:0] WORD_MASK   = {64{1'b1}} >> (64 - ENTRY_BITS);

    // Shadow copy of the table
    logic [63:0] tbl [CAPACITY];
    int          fill;

    // Results owed by the block, oldest first
    t_rsp        rsp_due_q [$];
    int          fails;
    int          checked;
    bit [4:0]    seen;
    int          peak;

    // Apply one request to the shadow table and return the result it must give
    function automatic t_rsp predict_table_op(t_req r);
        t_rsp        o;
        logic [63:0] w;
        int          p;
        bit          hit;
        o        = '0;
        o.status = ST_OK;
        w        = r.value & WORD_MASK;
        p        = r.position;
        hit      = 1'b0;
        case (r.mode)
            MODE_APPEND: begin
                if (fill >= CAPACITY) begin
                    o.status = ST_FULL;
                end else begin
                    tbl[fill] = w;
                    fill++;
                end
            end
            MODE_POP: begin
                if (fill == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    fill--;
                    o.entry_out = tbl[fill];
                end
            end
            MODE_INSERT: begin
                // full is checked before the position
                if (fill >= CAPACITY) begin
                    o.status = ST_FULL;
                end else if (p > fill) begin
                    o.status = ST_BADPOS;
                end else begin
                    for (int k = fill; k > p; k--) tbl[k] = tbl[k-1];
                    tbl[p] = w;
                    fill++;
                end
            end
            MODE_REMOVE: begin
                if (fill == 0) begin
                    o.status = ST_EMPTY;
                end else if (p >= fill) begin
                    o.status = ST_BADPOS;
                end else begin
                    o.entry_out = tbl[p];
                    for (int k = p; k + 1 < fill; k++) tbl[k] = tbl[k+1];
                    fill--;
                end
            end
            MODE_CHANGE: begin
                if (p >= fill) o.status = ST_BADPOS;
                else tbl[p] = w;
            end
            MODE_GET: begin
                if (p >= fill) o.status = ST_BADPOS;
                else o.entry_out = tbl[p];
            end
            MODE_SEARCH: begin
                // lowest matching index wins; an empty table never matches
                o.status = ST_NOTFOUND;
                for (int k = 0; k < fill; k++) begin
                    if (!hit && tbl[k] == w) begin
                        hit           = 1'b1;
                        o.status      = ST_OK;
                        o.found_index = 4'(k);
                    end
                end
            end
            default: ;
        endcase
        o.entry_out  = o.entry_out & WORD_MASK;
        o.fill_count = 5'(fill);
        if (fill > peak) peak = fill;
        return o;
    endfunction

    // Watch both channels at every edge
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            fill = 0;
            rsp_due_q.delete();
        end else begin
            // push first so a same-edge request never steals an older result
            if (i_start && !i_busy) begin
                rsp_due_q.push_back(predict_table_op(i_req));
            end
            if (i_strobe) begin
                if (rsp_due_q.size() == 0) begin
                    if (fails < MAX_REPORTS)
                        $display("unexpected result: status %0d entry %h index %0d fill %0d",
                                 i_rsp.status, i_rsp.entry_out, i_rsp.found_index,
                                 i_rsp.fill_count);
                    fails++;
                end else begin
                    want = rsp_due_q.pop_front();
                    checked++;
                    seen[want.status] = 1'b1;
                    if (i_rsp.status !== want.status || i_rsp.entry_out !== want.entry_out ||
                        i_rsp.found_index !== want.found_index ||
                        i_rsp.fill_count !== want.fill_count) begin
                        if (fails < MAX_REPORTS) begin
                            $display("result %0d mismatch: expected status %0d entry %h index %0d fill %0d",
                                     checked, want.status, want.entry_out, want.found_index,
                                     want.fill_count);
                            $display("                     got status %0d entry %h index %0d fill %0d",
                                     i_rsp.status, i_rsp.entry_out, i_rsp.found_index,
                                     i_rsp.fill_count);
                        end
                        fails++;
                    end
                end
            end
        end
        o_outstanding <= rsp_due_q.size();
        o_fail_count  <= fails;
        o_checked     <= checked;
        o_status_seen <= seen;
        o_fill_peak   <= peak;
    end

endmodule

>>> tb/sv/positional_array_table_top_tb.sv
// Testbench top for the positional array table: request stimulus, watchdog and verdict.
module positional_array_table_top_tb;
    import pat_pkg::*;

    localparam int unsigned CAPACITY      = DEF_CAPACITY;
    localparam int unsigned ENTRY_BITS    = DEF_ENTRY_BITS;
    localparam int          RANDOM_REQS   = 1630;
    localparam int          PHASE_LEN     = 60;
    localparam int          POOL_SIZE     = 8;
    localparam int          STALL_LIMIT   = 1000;
    localparam int          SETTLE_CYCLES = CAPACITY + 8;
    localparam logic [2:0]  MODE_UNUSED   = 3'd7;

    // Shape of the random request mix
    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIX
    } t_phase;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_start = 1'b0;
    t_req     i_req   = '0;
    logic     o_busy;
    logic     o_strobe;
    t_rsp     o_rsp;

    int       fail_count;
    int       outstanding;
    int       checked;
    bit [4:0] status_seen;
    int       fill_peak;

    int          stall_cycles = 0;
    int          sent         = 0;
    int          directed     = 0;
    bit          no_idle      = 1'b0;
    logic [63:0] value_pool [POOL_SIZE];

    positional_array_table_top #(
        .CAPACITY   (CAPACITY),
        .ENTRY_BITS (ENTRY_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    pat_table_checker #(
        .CAPACITY   (CAPACITY),
        .ENTRY_BITS (ENTRY_BITS)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_req         (i_req),
        .i_strobe      (o_strobe),
        .i_rsp         (o_rsp),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_status_seen (status_seen),
        .o_fill_peak   (fill_peak)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: cycles with neither a request nor a result taken
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results owed",
                     stall_cycles, outstanding);
            $display("positional_array_table_top regression: fail");
            $finish;
        end
    end

    // Sender gap: mostly none, sometimes short, rarely long
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 18);
        return $urandom_range(19, 60);
    endfunction

    // Hold one request until the block takes it, then idle for a random gap, which may be none
    task automatic issue_req(input logic [2:0] mode, input logic [4:0] pos,
                             input logic [63:0] val);
        t_req r;
        int   gap;
        r.mode     = mode;
        r.position = pos;
        r.value    = val;
        i_start   <= 1'b1;
        i_req     <= r;
        do @(posedge i_clk); while (o_busy);
        sent++;
        gap = idle_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending until every owed result has come back
    task automatic drain_wait();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic logic [2:0] pick_mode(t_phase ph);
        int    cut [7];
        t_mode order [7];
        int    roll;
        logic [2:0] m;
        order = '{MODE_APPEND, MODE_POP, MODE_INSERT, MODE_REMOVE,
                  MODE_CHANGE, MODE_GET, MODE_SEARCH};
        // cumulative percentages in the order above; the rest is the unused code
        case (ph)
            PH_FILL:  cut = '{35, 42, 72, 78, 85, 91, 99};
            PH_DRAIN: cut = '{5, 35, 40, 70, 78, 86, 98};
            default:  cut = '{15, 25, 40, 50, 62, 76, 98};
        endcase
        roll = $urandom_range(0, 99);
        m    = MODE_UNUSED;
        for (int k = 6; k >= 0; k--) begin
            if (roll < cut[k]) m = order[k];
        end
        return m;
    endfunction

    // Positions lean low so that more requests land inside the table
    function automatic logic [4:0] pick_pos();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 5'($urandom_range(0, $urandom_range(0, CAPACITY)));
        if (roll < 92) return 5'($urandom_range(0, CAPACITY));
        return 5'($urandom_range(CAPACITY + 1, 31));
    endfunction

    // Words mostly from a small pool so searches hit and duplicates occur
    function automatic logic [63:0] pick_value();
        if ($urandom_range(0, 3) != 0) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    initial begin : stimulus
        t_phase     phase;
        int         in_phase;
        int         phase_num;
        int         counted;
        logic [2:0] mode;

        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) value_pool[k] = {$urandom, $urandom};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table corner cases
        issue_req(MODE_POP,    5'd0,  '0);
        issue_req(MODE_REMOVE, 5'd0,  '0);
        issue_req(MODE_GET,    5'd0,  '0);
        issue_req(MODE_CHANGE, 5'd0,  64'h1);
        issue_req(MODE_SEARCH, 5'd0,  '0);
        issue_req(MODE_UNUSED, 5'd31, '1);
        issue_req(MODE_INSERT, 5'd1,  64'h1234);
        // build a short table with extreme words
        issue_req(MODE_INSERT, 5'd0,  '1);
        issue_req(MODE_APPEND, 5'd0,  '0);
        issue_req(MODE_APPEND, 5'd16, 64'h8000_0000_0000_0001);
        issue_req(MODE_INSERT, 5'd3,  64'h5a5a_5a5a_5a5a_5a5a);
        // searches: first entry, last entry, no match
        issue_req(MODE_SEARCH, 5'd0,  '1);
        issue_req(MODE_SEARCH, 5'd0,  64'h5a5a_5a5a_5a5a_5a5a);
        issue_req(MODE_SEARCH, 5'd0,  64'h7);
        issue_req(MODE_CHANGE, 5'd3,  64'ha5a5_a5a5_a5a5_a5a5);
        issue_req(MODE_GET,    5'd3,  '0);
        issue_req(MODE_CHANGE, 5'd4,  64'hffff);
        issue_req(MODE_REMOVE, 5'd1,  '0);
        issue_req(MODE_REMOVE, 5'd3,  '0);
        issue_req(MODE_GET,    5'd16, '0);
        issue_req(MODE_REMOVE, 5'd0,  '0);
        directed = sent;
        drain_wait();

        // Random: phases that fill, drain or mix, starting with a fill
        phase     = PH_FILL;
        in_phase  = 0;
        phase_num = 0;
        counted   = 0;
        while (counted < RANDOM_REQS) begin
            if (in_phase == PHASE_LEN) begin
                in_phase = 0;
                phase_num++;
                phase    = t_phase'($urandom_range(0, 2));
                no_idle  = ($urandom_range(0, 3) == 0);
                value_pool[$urandom_range(0, POOL_SIZE - 1)] = {$urandom, $urandom};
                if (phase_num % 6 == 0) drain_wait();
            end
            mode = pick_mode(phase);
            issue_req(mode, pick_pos(), pick_value());
            if (mode != MODE_UNUSED) counted++;
            in_phase++;
        end

        drain_wait();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d requests issued (%0d directed), %0d results checked",
                 sent, directed, checked);
        $display("table fill peaked at %0d of %0d, status codes seen (high code first) %b",
                 fill_peak, CAPACITY, status_seen);
        if (fail_count == 0) begin
            $display("positional_array_table_top regression: pass");
        end else begin
            $display("positional_array_table_top regression: fail");
        end
        $finish;
    end

endmodule
